// ===== rtl/dqsr_pkg.sv =====
// Package for the double-ended queue with sort and reverse.
// Holds the command codes and the sequencer state type; depends on nothing.
package dqsr_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_REVERSE    = 3'd5,
    OP_SORT       = 3'd6,
    OP_NOP        = 3'd7
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REV_RA,
    ST_REV_RB,
    ST_REV_WA,
    ST_REV_WB,
    ST_SRT_RK,
    ST_SRT_LK,
    ST_SRT_CMP,
    ST_SRT_WK,
    ST_RD_F,
    ST_RD_B,
    ST_RD_W,
    ST_DONE
  } state_e;

  localparam int unsigned WordW = 32;

endpackage

// ===== rtl/dqsr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package needed.
module dqsr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/deque_with_sort_reverse.sv =====
// Push, pop, clear and no-op read the front and back words before the done state (none
// when empty). Reverse adds two reads and two writes per swapped pair; sort adds a key read,
// a neighbour read and a compare per inserted word plus a compare per shifted word, all set
// by the single read port of the word store. One command is worked at a time; the next is
// taken while the result waits, but not before the last command reaches its done state.
// Reset (rst_ni low, asynchronous) empties the queue; the store itself is not cleared.
module deque_with_sort_reverse #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Command channel.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  dqsr_pkg::opcode_e s_axis_tuser_i, // [2:0] opcode
  // Result channel.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0 up: front_value(32), back_value(32), entry_count,
  // is_empty(1), ignored(1), zero padding to whole bytes.
  output logic [((66 + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  import dqsr_pkg::*;

  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned OutBits = 66 + CW;
  localparam int unsigned OutW    = ((OutBits + 7) / 8) * 8;

  // Sequencer and queue pointers.
  state_e           state_q, state_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    i_q, i_d;
  logic [CW-1:0]    j_q, j_d;
  logic             ign_q, ign_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  logic [WordW-1:0] tmp_q, tmp_d;
  logic [WordW-1:0] front_q, front_d;
  logic [WordW-1:0] back_q, back_d;
  logic [OutW-1:0]  out_q, out_d;

  // Store port.
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [WordW-1:0] wdata, rdata;

  // Physical position of the word at a given offset from the front.
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(head) + (CW + 1)'(off);
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dqsr_ram #(
    .WIDTH(WordW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      ign_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      ign_q       <= ign_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q   <= tmp_d;
    front_q <= front_d;
    back_q  <= back_d;
    out_q   <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    ign_d       = ign_q;
    out_valid_d = out_valid_q;
    tmp_d       = tmp_q;
    front_d     = front_q;
    back_d      = back_q;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = s_axis_tdata_i;
    raddr       = '0;

    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          ign_d   = 1'b0;
          state_d = ST_RD_F;
          case (s_axis_tuser_i)
            OP_PUSH_FRONT: begin
              if (count_q == CW'(DEPTH)) begin
                ign_d = 1'b1;
              end else begin
                head_d  = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
                we      = 1'b1;
                waddr   = head_d;
                count_d = count_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (count_q == CW'(DEPTH)) begin
                ign_d = 1'b1;
              end else begin
                we      = 1'b1;
                waddr   = slot(head_q, count_q);
                count_d = count_q + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count_q == '0) begin
                ign_d = 1'b1;
              end else begin
                head_d  = slot(head_q, CW'(1));
                count_d = count_q - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (count_q == '0) begin
                ign_d = 1'b1;
              end else begin
                count_d = count_q - 1'b1;
              end
            end
            OP_CLEAR: begin
              head_d  = '0;
              count_d = '0;
            end
            OP_REVERSE: begin
              if (count_q >= CW'(2)) begin
                i_d     = '0;
                j_d     = count_q - 1'b1;
                state_d = ST_REV_RA;
              end
            end
            OP_SORT: begin
              if (count_q >= CW'(2)) begin
                i_d     = CW'(1);
                state_d = ST_SRT_RK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Reverse swaps the pair at offsets i and j, moving inward.
      ST_REV_RA: begin
        raddr   = slot(head_q, i_q);
        state_d = ST_REV_RB;
      end
      ST_REV_RB: begin
        raddr   = slot(head_q, j_q);
        tmp_d   = rdata;
        state_d = ST_REV_WA;
      end
      ST_REV_WA: begin
        we      = 1'b1;
        waddr   = slot(head_q, i_q);
        wdata   = rdata;
        state_d = ST_REV_WB;
      end
      ST_REV_WB: begin
        we    = 1'b1;
        waddr = slot(head_q, j_q);
        wdata = tmp_q;
        i_d   = i_q + 1'b1;
        j_d   = j_q - 1'b1;
        if ((CW + 1)'(i_q) + (CW + 1)'(2) < (CW + 1)'(j_q)) begin
          state_d = ST_REV_RA;
        end else begin
          state_d = ST_RD_F;
        end
      end

      // Insertion sort: the key at offset i sinks past larger words.
      ST_SRT_RK: begin
        raddr   = slot(head_q, i_q);
        j_d     = i_q;
        state_d = ST_SRT_LK;
      end
      ST_SRT_LK: begin
        tmp_d   = rdata;
        raddr   = slot(head_q, j_q - 1'b1);
        state_d = ST_SRT_CMP;
      end
      ST_SRT_CMP: begin
        we    = 1'b1;
        waddr = slot(head_q, j_q);
        if ($signed(rdata) > $signed(tmp_q)) begin
          wdata = rdata;
          j_d   = j_q - 1'b1;
          if (j_q == CW'(1)) begin
            state_d = ST_SRT_WK;
          end else begin
            raddr = slot(head_q, j_q - CW'(2));
          end
        end else begin
          wdata = tmp_q;
          i_d   = i_q + 1'b1;
          state_d = (i_q + 1'b1 < count_q) ? ST_SRT_RK : ST_RD_F;
        end
      end
      ST_SRT_WK: begin
        we      = 1'b1;
        waddr   = slot(head_q, j_q);
        wdata   = tmp_q;
        i_d     = i_q + 1'b1;
        state_d = (i_q + 1'b1 < count_q) ? ST_SRT_RK : ST_RD_F;
      end

      // Refresh the front and back words for the result.
      ST_RD_F: begin
        if (count_q == '0) begin
          front_d = '1;
          back_d  = '1;
          state_d = ST_DONE;
        end else begin
          raddr   = head_q;
          state_d = ST_RD_B;
        end
      end
      ST_RD_B: begin
        front_d = rdata;
        raddr   = slot(head_q, count_q - 1'b1);
        state_d = ST_RD_W;
      end
      ST_RD_W: begin
        back_d  = rdata;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_d = OutW'({ign_q, (count_q == '0), count_q, back_q, front_q});
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== tb/tb_deque_with_sort_reverse.sv =====
// Testbench for deque_with_sort_reverse: random and directed commands on the stream
// input, results checked word by word against a behavioral deque held in the bench.
// Depends on dqsr_pkg and the deque_with_sort_reverse RTL.
module tb_deque_with_sort_reverse;
  import dqsr_pkg::*;

  localparam int unsigned Depth = 1024;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned OutW = ((66 + CntW + 7) / 8) * 8;

  typedef struct packed {
    opcode_e     op;
    logic [31:0] value;
  } command_t;

  typedef struct packed {
    logic [31:0]     front;
    logic [31:0]     back;
    logic [CntW-1:0] count;
    logic            empty;
    logic            dropped;
  } status_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  opcode_e s_axis_tuser_i = OP_NOP;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [OutW-1:0] m_axis_tdata_o;

  deque_with_sort_reverse #(.DEPTH(Depth)) dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Behavioral deque: a plain queue, front at index 0.
  logic signed [31:0] deque_words[$];
  command_t pending_cmds[$];
  status_t  expected_status[$];
  int errors = 0;
  bit calm = 1'b0;        // no idling in the final stretch
  bit hold_off = 1'b0;    // long receiver stall
  int sent = 0;

  function automatic status_t apply_command(command_t c);
    status_t s;
    logic signed [31:0] key;
    int j;
    s = '0;
    case (c.op)
      OP_PUSH_FRONT:
        if (deque_words.size() >= Depth) s.dropped = 1'b1;
        else deque_words.insert(0, c.value);
      OP_PUSH_BACK:
        if (deque_words.size() >= Depth) s.dropped = 1'b1;
        else deque_words.insert(deque_words.size(), c.value);
      OP_POP_FRONT:
        if (deque_words.size() == 0) s.dropped = 1'b1;
        else deque_words.delete(0);
      OP_POP_BACK:
        if (deque_words.size() == 0) s.dropped = 1'b1;
        else deque_words.delete(deque_words.size() - 1);
      OP_CLEAR: deque_words.delete();
      OP_REVERSE: deque_words.reverse();
      OP_SORT:
        // Stable insertion sort, signed ascending.
        for (int i = 1; i < deque_words.size(); i++) begin
          key = deque_words[i];
          j = i;
          while (j > 0 && deque_words[j-1] > key) begin
            deque_words[j] = deque_words[j-1];
            j--;
          end
          deque_words[j] = key;
        end
      default: ;
    endcase
    if (deque_words.size() == 0) begin
      s.front = '1;
      s.back = '1;
      s.empty = 1'b1;
    end else begin
      s.front = deque_words[0];
      s.back = deque_words[deque_words.size()-1];
    end
    s.count = CntW'(deque_words.size());
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic add_cmd(opcode_e op, logic [31:0] v);
    command_t c;
    c.op = op;
    c.value = v;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Driver: one word per handshake, random idle bursts.
  int send_gap = 0;
  command_t next_cmd;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_status.insert(expected_status.size(),
                               apply_command({s_axis_tuser_i, s_axis_tdata_i}));
        sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds[0];
          pending_cmds.delete(0);
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i <= next_cmd.op;
          s_axis_tdata_i <= next_cmd.value;
          if (!calm && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 16);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result, stalls at random.
  int recv_gap = 0;
  status_t got_status, want_status;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_status = {m_axis_tdata_o[31:0], m_axis_tdata_o[63:32],
                      m_axis_tdata_o[64+CntW-1:64], m_axis_tdata_o[64+CntW],
                      m_axis_tdata_o[65+CntW]};
        if (expected_status.size() == 0) begin
          report_mismatch("unexpected result", got_status.front, '0);
        end else begin
          want_status = expected_status[0];
          expected_status.delete(0);
          if (got_status.front !== want_status.front)
            report_mismatch("front", got_status.front, want_status.front);
          if (got_status.back !== want_status.back)
            report_mismatch("back", got_status.back, want_status.back);
          if (got_status.count !== want_status.count)
            report_mismatch("count", 32'(got_status.count), 32'(want_status.count));
          if (got_status.empty !== want_status.empty)
            report_mismatch("empty", 32'(got_status.empty), 32'(want_status.empty));
          if (got_status.dropped !== want_status.dropped)
            report_mismatch("ignored", 32'(got_status.dropped), 32'(want_status.dropped));
        end
      end
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!calm && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 16);
      end
    end
  end

  // Long receiver stall, timed in its own process.
  initial begin
    wait (sent > 40);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7) - 4;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int total;
    opcode_e op;
    // Directed: empty-queue cases, extremes, each command.
    add_cmd(OP_POP_FRONT, 32'h0);
    add_cmd(OP_POP_BACK, 32'hffff_ffff);
    add_cmd(OP_REVERSE, 32'h0);
    add_cmd(OP_SORT, 32'h0);
    add_cmd(OP_PUSH_BACK, 32'h7fff_ffff);
    add_cmd(OP_SORT, 32'h0);
    add_cmd(OP_REVERSE, 32'h0);
    add_cmd(OP_PUSH_FRONT, 32'h8000_0000);
    add_cmd(OP_PUSH_BACK, 32'hffff_ffff);
    add_cmd(OP_PUSH_FRONT, 32'h0000_0005);
    add_cmd(OP_PUSH_BACK, 32'h0000_0005);
    add_cmd(OP_PUSH_BACK, 32'h0);
    add_cmd(OP_REVERSE, 32'h0);
    add_cmd(OP_SORT, 32'h0);
    add_cmd(OP_NOP, 32'hdead_beef);
    add_cmd(OP_POP_FRONT, 32'h0);
    add_cmd(OP_POP_BACK, 32'h0);
    add_cmd(OP_CLEAR, 32'h0);
    add_cmd(OP_PUSH_FRONT, 32'h1234_5678);
    add_cmd(OP_POP_BACK, 32'h0);
    // Random: mostly pushes/pops; sort and reverse rare since they are slow.
    for (int i = 0; i < 630; i++) begin
      case ($urandom_range(0, 39))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: op = OP_PUSH_BACK;
        12, 13, 14, 15, 16, 17, 18, 19, 20, 21: op = OP_PUSH_FRONT;
        22, 23, 24, 25, 26, 27: op = OP_POP_FRONT;
        28, 29, 30, 31, 32, 33: op = OP_POP_BACK;
        34: op = OP_CLEAR;
        35, 36: op = OP_REVERSE;
        37, 38: op = OP_SORT;
        default: op = OP_NOP;
      endcase
      add_cmd(op, rand_word());
    end
    // Short run of front pushes, then sort and reverse it.
    add_cmd(OP_CLEAR, 32'h0);
    for (int i = 0; i < 12; i++) add_cmd(OP_PUSH_FRONT, rand_word());
    add_cmd(OP_SORT, 32'h0);
    add_cmd(OP_REVERSE, 32'h0);
    total = pending_cmds.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (sent >= total - 100);
    calm = 1'b1;
    wait (sent == total && expected_status.size() == 0);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
